// ----- design/sps_pkg.sv -----
// ----------------------------------------------------------------------------
// Stepper pulse scheduler package
// Shared widths, codes and types for the pulse scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package sps_pkg;

   localparam int BURST_PULSES_DEF = 16;
   localparam int COUNT_LIMIT_DEF  = 65536;
   localparam int QUEUE_DEPTH_DEF  = 8;

   localparam int CMD_W    = 2;
   localparam int MODE_W   = 2;
   localparam int PERIOD_W = 16;
   localparam int STEPS_W  = 24;
   localparam int TIMER_W  = 16;
   localparam int CMP_W    = 16;
   localparam int PW_W     = 16;
   localparam int DONE_W   = 6;

   localparam int EVQ_DEPTH = 2;
   localparam int RED_LANES = 3;

   localparam logic [PW_W-1:0] PULSE_WIDTH_RST = 16'd10;

   localparam logic REQ_POSITION = 1'b0;
   localparam logic REQ_VELOCITY = 1'b1;

   localparam int LANE_BASE   = 0;
   localparam int LANE_PERIOD = 1;
   localparam int LANE_WIDTH  = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_ENQUEUE = 2'd0,
      CMD_START   = 2'd1,
      CMD_DONE    = 2'd2,
      CMD_ERROR   = 2'd3
   } cmd_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_OFF      = 2'd0,
      MODE_POSITION = 2'd1,
      MODE_VELOCITY = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_FETCH,
      BK_DECODE,
      BK_REDUCE,
      BK_BURST,
      BK_STATUS
   } back_state_type;

   typedef struct packed {
      cmd_type               cmd;
      logic                  req_mode;
      logic [PERIOD_W-1:0]   period;
      logic [STEPS_W-1:0]    steps;
      logic [TIMER_W-1:0]    timer;
   } event_type;

   typedef struct packed {
      logic                  req_mode;
      logic [PERIOD_W-1:0]   period;
      logic [STEPS_W-1:0]    steps;
   } move_type;

   typedef struct packed {
      logic busy;
      logic done;
   } red_status_type;

endpackage

`default_nettype wire

// ----- design/sps_ifs.sv -----
// ----------------------------------------------------------------------------
// Stepper pulse scheduler channel interfaces
// Request, response and register write channels with valid/ready transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface sps_req_if;
   logic                          valid;
   logic                          ready;
   logic [sps_pkg::CMD_W-1:0]     command;
   logic                          req_mode;
   logic [sps_pkg::PERIOD_W-1:0]  req_period;
   logic [sps_pkg::STEPS_W-1:0]   req_steps;
   logic [sps_pkg::TIMER_W-1:0]   timer_count;

   modport source (output valid, command, req_mode, req_period, req_steps, timer_count,
                   input ready);
   modport sink   (input valid, command, req_mode, req_period, req_steps, timer_count,
                   output ready);
endinterface

interface sps_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          word_valid;
   logic [sps_pkg::CMP_W-1:0]     compare_value;
   logic                          last;
   logic [sps_pkg::MODE_W-1:0]    mode_now;
   logic                          output_enabled;
   logic [sps_pkg::DONE_W-1:0]    pulses_done;
   logic                          request_dropped;

   modport source (output valid, word_valid, compare_value, last, mode_now, output_enabled,
                   pulses_done, request_dropped, input ready);
   modport sink   (input valid, word_valid, compare_value, last, mode_now, output_enabled,
                   pulses_done, request_dropped, output ready);
endinterface

interface sps_csr_if;
   logic                          valid;
   logic                          ready;
   logic [sps_pkg::PW_W-1:0]      pulse_width;

   modport source (output valid, pulse_width, input ready);
   modport sink   (input valid, pulse_width, output ready);
endinterface

`default_nettype wire

// ----- design/stepper_pulse_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// Stepper pulse scheduler
// Move request queue feeding a compare word burst generator.
// ----------------------------------------------------------------------------
// Channels: req_ch takes one event per transfer (enqueue a move, start check,
// transfer complete, transfer error). rsp_ch returns the result items of each
// event in order: one compare word per item while a burst runs, alternating
// rise and fall, or a single status item; last marks the final item of an
// event. csr_ch writes pulse_width; write it only while the block is idle.
// An event without a burst gives a single status item. A start that finds the
// motor off reads queue entries (registered queue memory), then runs the
// modulo reduction of base, period and pulse width (reciprocal multiply,
// subtract, correct); then 2 x pulses words follow at one per cycle while
// rsp_ch is not stalled. The executor handles one event at a time and takes
// no new event until its burst or status item is out. The front end and a
// 2-entry event queue keep taking req_ch transfers while the executor works.
// Reset clears the queue pointers and motor state; pulse width resets to 10.
// A stalled rsp_ch holds its item and pauses the executor; req_ch backs up
// once the event queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_pulse_scheduler_unit #(
   parameter int BURST_PULSES = sps_pkg::BURST_PULSES_DEF,
   parameter int COUNT_LIMIT  = sps_pkg::COUNT_LIMIT_DEF,
   parameter int QUEUE_DEPTH  = sps_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   sps_req_if.sink      req_ch,
   sps_rsp_if.source    rsp_ch,
   sps_csr_if.sink      csr_ch
);
   import sps_pkg::*;

   logic                fe_valid;
   logic                fe_ready;
   event_type           fe_ev;
   logic                bk_valid;
   logic                bk_ready;
   event_type           bk_ev;
   logic [PW_W-1:0]     pulse_width;

   sps_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .csr         (csr_ch),
      .ev_valid    (fe_valid),
      .ev_ready    (fe_ready),
      .ev          (fe_ev),
      .pulse_width (pulse_width)
   );

   sps_evq u_evq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fe_valid),
      .in_ready  (fe_ready),
      .in_ev     (fe_ev),
      .out_valid (bk_valid),
      .out_ready (bk_ready),
      .out_ev    (bk_ev)
   );

   sps_back #(
      .BURST_PULSES (BURST_PULSES),
      .COUNT_LIMIT  (COUNT_LIMIT),
      .QUEUE_DEPTH  (QUEUE_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .ev_valid    (bk_valid),
      .ev_ready    (bk_ready),
      .ev          (bk_ev),
      .pulse_width (pulse_width),
      .rsp         (rsp_ch)
   );

endmodule

`default_nettype wire

// ----- design/sps_front.sv -----
// ----------------------------------------------------------------------------
// Stepper pulse scheduler front end
// Accepts request transfers, classifies the command into an event and holds
// the pulse width register.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   sps_req_if.sink                      req,
   sps_csr_if.sink                      csr,
   output logic                         ev_valid,
   input  wire logic                    ev_ready,
   output sps_pkg::event_type           ev,
   output logic [sps_pkg::PW_W-1:0]     pulse_width
);
   import sps_pkg::*;

   logic                ev_valid_ff, ev_valid_in;
   event_type           ev_ff, ev_in;
   logic [PW_W-1:0]     pw_ff, pw_in;
   logic                take;

   assign req.ready   = !ev_valid_ff || ev_ready;
   assign take        = req.valid && req.ready;
   assign csr.ready   = 1'b1;
   assign ev_valid    = ev_valid_ff;
   assign ev          = ev_ff;
   assign pulse_width = pw_ff;

   always_comb begin
      ev_valid_in = ev_valid_ff && !ev_ready;
      ev_in       = ev_ff;
      pw_in       = pw_ff;
      if (csr.valid) begin
         pw_in = csr.pulse_width;
      end
      if (take) begin
         ev_valid_in     = 1'b1;
         ev_in.cmd       = cmd_type'(req.command);
         ev_in.req_mode  = 1'b0;
         ev_in.period    = '0;
         ev_in.steps     = '0;
         ev_in.timer     = req.timer_count;
         case (cmd_type'(req.command))
            CMD_ENQUEUE: begin
               ev_in.req_mode = req.req_mode;
               ev_in.period   = req.req_period;
               ev_in.steps    = (req.req_mode == REQ_VELOCITY) ? '0 : req.req_steps;
            end
            CMD_START, CMD_DONE: begin
               ev_in.timer = req.timer_count;
            end
            default: begin
               ev_in.timer = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_valid_ff <= 1'b0;
         pw_ff       <= PULSE_WIDTH_RST;
      end else begin
         ev_valid_ff <= ev_valid_in;
         pw_ff       <= pw_in;
      end
      ev_ff <= ev_in;
   end

endmodule

`default_nettype wire

// ----- design/sps_evq.sv -----
// ----------------------------------------------------------------------------
// Stepper pulse scheduler event queue
// Short FIFO between front end and executor.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_evq (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire sps_pkg::event_type in_ev,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output sps_pkg::event_type     out_ev
);
   import sps_pkg::*;

   localparam int PTR_W = $clog2(EVQ_DEPTH);
   localparam int CNT_W = $clog2(EVQ_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL     = CNT_W'(EVQ_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(EVQ_DEPTH - 1);

   event_type           slot_ff [EVQ_DEPTH];
   logic [PTR_W-1:0]    rd_ff, rd_in, wr_ff, wr_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                push, pop;

   assign in_ready  = cnt_ff != FULL;
   assign out_valid = cnt_ff != '0;
   assign out_ev    = slot_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      rd_in  = rd_ff;
      wr_in  = wr_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_LAST) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_LAST) ? '0 : rd_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= '0;
         wr_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= in_ev;
      end
   end

endmodule

`default_nettype wire

// ----- design/sps_reduce.sv -----
// ----------------------------------------------------------------------------
// Stepper pulse scheduler modulo unit
// Reduces three 16-bit values modulo the timer range by reciprocal multiply,
// subtract and one correction.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_reduce #(
   parameter int COUNT_LIMIT = sps_pkg::COUNT_LIMIT_DEF
) (
   input  wire logic                                              clock,
   input  wire logic                                              reset,
   input  wire logic                                              start,
   input  wire logic [sps_pkg::RED_LANES-1:0][sps_pkg::CMP_W-1:0] value,
   output sps_pkg::red_status_type                                status,
   output logic [sps_pkg::RED_LANES-1:0][$clog2(COUNT_LIMIT)-1:0] result
);
   import sps_pkg::*;

   localparam int CW      = $clog2(COUNT_LIMIT);
   localparam int RECIP_W = 32;
   localparam int PROD_W  = CMP_W + RECIP_W;
   localparam int SCALE_W = 2 * CMP_W + 1;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_W) / 64'(COUNT_LIMIT));
   localparam logic [CMP_W:0]     LIM   = (CMP_W + 1)'(COUNT_LIMIT);

   logic                                  stage1_ff, stage1_in;
   logic                                  stage2_ff, stage2_in;
   logic                                  done_ff, done_in;
   logic                                  busy;
   logic [RED_LANES-1:0][CMP_W-1:0]       src_ff, src_in;
   logic [RED_LANES-1:0][CMP_W-1:0]       quo_ff, quo_in;
   logic [RED_LANES-1:0][CMP_W:0]         raw_ff, raw_in;
   logic [RED_LANES-1:0][CW-1:0]          rem_ff, rem_in;
   logic [PROD_W-1:0]                     prod;
   logic [SCALE_W-1:0]                    scaled;
   logic [CMP_W:0]                        fold;

   assign busy        = stage1_ff || stage2_ff;
   assign status.busy = busy;
   assign status.done = done_ff;
   assign result      = rem_ff;

   always_comb begin
      stage1_in = 1'b0;
      stage2_in = stage1_ff;
      done_in   = stage2_ff;
      src_in    = src_ff;
      quo_in    = quo_ff;
      raw_in    = raw_ff;
      rem_in    = rem_ff;
      prod      = '0;
      scaled    = '0;
      fold      = '0;
      if (start && !busy) begin
         stage1_in = 1'b1;
         src_in    = value;
         for (int i = 0; i < RED_LANES; i++) begin
            prod      = PROD_W'(value[i]) * PROD_W'(RECIP);
            quo_in[i] = prod[PROD_W-1:RECIP_W];
         end
      end
      if (stage1_ff) begin
         for (int i = 0; i < RED_LANES; i++) begin
            scaled    = SCALE_W'(quo_ff[i]) * SCALE_W'(LIM);
            raw_in[i] = {1'b0, src_ff[i]} - scaled[CMP_W:0];
         end
      end
      if (stage2_ff) begin
         for (int i = 0; i < RED_LANES; i++) begin
            fold      = (raw_ff[i] >= LIM) ? raw_ff[i] - LIM : raw_ff[i];
            rem_in[i] = fold[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage1_ff <= 1'b0;
         stage2_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         stage1_ff <= stage1_in;
         stage2_ff <= stage2_in;
         done_ff   <= done_in;
      end
      src_ff <= src_in;
      quo_ff <= quo_in;
      raw_ff <= raw_in;
      rem_ff <= rem_in;
   end

endmodule

`default_nettype wire

// ----- design/sps_back.sv -----
// ----------------------------------------------------------------------------
// Stepper pulse scheduler executor
// Holds the move request queue and motor state, carries out each event and
// emits compare word bursts or a status item.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_back #(
   parameter int BURST_PULSES = sps_pkg::BURST_PULSES_DEF,
   parameter int COUNT_LIMIT  = sps_pkg::COUNT_LIMIT_DEF,
   parameter int QUEUE_DEPTH  = sps_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   ev_valid,
   output logic                        ev_ready,
   input  wire sps_pkg::event_type     ev,
   input  wire logic [sps_pkg::PW_W-1:0] pulse_width,
   sps_rsp_if.source                   rsp
);
   import sps_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int BW    = $clog2(BURST_PULSES + 1);
   localparam int CW    = $clog2(COUNT_LIMIT);
   localparam logic [CNT_W-1:0] QFULL      = CNT_W'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] QONE       = CNT_W'(1);
   localparam logic [PTR_W-1:0] PTR_LAST   = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [BW-1:0]    BURST_FULL = BW'(BURST_PULSES);
   localparam logic [CW:0]      LIM        = (CW + 1)'(COUNT_LIMIT);

   back_state_type       state_ff, state_in;

   move_type             mem [QUEUE_DEPTH];
   move_type             head_ff;
   logic                 mem_we;
   move_type             mem_wdata;

   logic [PTR_W-1:0]     rd_ff, rd_in, wr_ff, wr_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   mode_type             mode_ff, mode_in;
   logic                 on_ff, on_in;
   logic [PERIOD_W-1:0]  period_ff, period_in;
   logic [STEPS_W-1:0]   steps_ff, steps_in;
   logic [BW-1:0]        burst_ff, burst_in;
   logic [CW-1:0]        last_ff, last_in;
   logic [TIMER_W-1:0]   timer_ff, timer_in;
   logic [CMP_W-1:0]     base_ff, base_in;
   logic                 handover_ff, handover_in;
   logic [BW-1:0]        done_ff, done_in;
   logic                 dropped_ff, dropped_in;
   logic [CW-1:0]        prev_ff, prev_in;
   logic                 phase_ff, phase_in;
   logic [BW-1:0]        pcnt_ff, pcnt_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 word_valid_ff, word_valid_in;
   logic [CMP_W-1:0]     cmp_ff, cmp_in;
   logic                 last_item_ff, last_item_in;
   logic [MODE_W-1:0]    mode_out_ff, mode_out_in;
   logic                 on_out_ff, on_out_in;
   logic [DONE_W-1:0]    done_out_ff, done_out_in;
   logic                 drop_out_ff, drop_out_in;

   logic                 out_free;
   logic [STEPS_W-1:0]   steps_sub;
   logic                 head_skip;
   logic                 head_swap;
   logic                 word_last;
   logic [CW:0]          sum;
   logic [CW-1:0]        word;

   logic                                  red_start;
   red_status_type                        red_status;
   logic [RED_LANES-1:0][CMP_W-1:0]       red_value;
   logic [RED_LANES-1:0][CW-1:0]          red_result;

   function automatic logic [BW-1:0] burst_cap(input logic [STEPS_W-1:0] steps);
      logic [BW-1:0] cap;
      cap = BURST_FULL;
      if (steps < STEPS_W'(BURST_PULSES)) begin
         cap = steps[BW-1:0];
      end
      return cap;
   endfunction

   sps_reduce #(
      .COUNT_LIMIT (COUNT_LIMIT)
   ) u_reduce (
      .clock  (clock),
      .reset  (reset),
      .start  (red_start),
      .value  (red_value),
      .status (red_status),
      .result (red_result)
   );

   assign ev_ready  = state_ff == BK_IDLE;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign steps_sub = (steps_ff >= STEPS_W'(burst_ff)) ? steps_ff - STEPS_W'(burst_ff) : '0;
   assign head_swap = handover_ff && (head_ff.req_mode == REQ_VELOCITY);
   assign head_skip = (head_ff.req_mode == REQ_POSITION) && (head_ff.steps == '0);
   assign word_last = phase_ff && ((pcnt_ff + BW'(1)) == burst_ff);
   assign sum       = {1'b0, prev_ff} + (phase_ff ? (CW + 1)'(red_result[LANE_WIDTH])
                                                  : (CW + 1)'(red_result[LANE_PERIOD]));
   assign word      = (sum >= LIM) ? CW'(sum - LIM) : sum[CW-1:0];

   assign red_start              = (state_ff == BK_REDUCE) && !red_status.busy &&
                                   !red_status.done;
   assign red_value[LANE_BASE]   = base_ff;
   assign red_value[LANE_PERIOD] = period_ff;
   assign red_value[LANE_WIDTH]  = pulse_width;

   assign mem_wdata.req_mode = ev.req_mode;
   assign mem_wdata.period   = ev.period;
   assign mem_wdata.steps    = ev.steps;

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.word_valid      = word_valid_ff;
   assign rsp.compare_value   = cmp_ff;
   assign rsp.last            = last_item_ff;
   assign rsp.mode_now        = mode_out_ff;
   assign rsp.output_enabled  = on_out_ff;
   assign rsp.pulses_done     = done_out_ff;
   assign rsp.request_dropped = drop_out_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (ev_valid) begin
               case (ev.cmd)
                  CMD_START: begin
                     state_in = (mode_ff == MODE_OFF && cnt_ff != '0) ? BK_FETCH : BK_STATUS;
                  end
                  CMD_DONE: begin
                     case (mode_ff)
                        MODE_POSITION: begin
                           if (steps_sub != '0) begin
                              state_in = BK_REDUCE;
                           end else begin
                              state_in = (cnt_ff != '0) ? BK_FETCH : BK_STATUS;
                           end
                        end
                        MODE_VELOCITY: begin
                           state_in = (cnt_ff == '0) ? BK_REDUCE : BK_FETCH;
                        end
                        default: begin
                           state_in = BK_STATUS;
                        end
                     endcase
                  end
                  default: begin
                     state_in = BK_STATUS;
                  end
               endcase
            end
         end
         BK_FETCH: begin
            state_in = BK_DECODE;
         end
         BK_DECODE: begin
            if (!head_swap && head_skip) begin
               state_in = (cnt_ff != QONE) ? BK_FETCH : BK_STATUS;
            end else begin
               state_in = BK_REDUCE;
            end
         end
         BK_REDUCE: begin
            if (red_status.done) begin
               state_in = BK_BURST;
            end
         end
         BK_BURST: begin
            if (out_free && word_last) begin
               state_in = BK_IDLE;
            end
         end
         BK_STATUS: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      mem_we        = 1'b0;
      rd_in         = rd_ff;
      wr_in         = wr_ff;
      cnt_in        = cnt_ff;
      mode_in       = mode_ff;
      on_in         = on_ff;
      period_in     = period_ff;
      steps_in      = steps_ff;
      burst_in      = burst_ff;
      last_in       = last_ff;
      timer_in      = timer_ff;
      base_in       = base_ff;
      handover_in   = handover_ff;
      done_in       = done_ff;
      dropped_in    = dropped_ff;
      prev_in       = prev_ff;
      phase_in      = phase_ff;
      pcnt_in       = pcnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      word_valid_in = word_valid_ff;
      cmp_in        = cmp_ff;
      last_item_in  = last_item_ff;
      mode_out_in   = mode_out_ff;
      on_out_in     = on_out_ff;
      done_out_in   = done_out_ff;
      drop_out_in   = drop_out_ff;

      case (state_ff)
         BK_IDLE: begin
            if (ev_valid) begin
               timer_in    = ev.timer;
               dropped_in  = 1'b0;
               done_in     = '0;
               handover_in = 1'b0;
               case (ev.cmd)
                  CMD_ENQUEUE: begin
                     if (cnt_ff == QFULL) begin
                        dropped_in = 1'b1;
                     end else begin
                        mem_we = 1'b1;
                        wr_in  = (wr_ff == PTR_LAST) ? '0 : wr_ff + 1'b1;
                        cnt_in = cnt_ff + 1'b1;
                     end
                  end
                  CMD_DONE: begin
                     case (mode_ff)
                        MODE_POSITION: begin
                           done_in  = burst_ff;
                           steps_in = steps_sub;
                           if (steps_sub != '0) begin
                              burst_in = burst_cap(steps_sub);
                              base_in  = CMP_W'(last_ff);
                           end else begin
                              mode_in = MODE_OFF;
                              on_in   = 1'b0;
                           end
                        end
                        MODE_VELOCITY: begin
                           done_in = burst_ff;
                           if (cnt_ff == '0) begin
                              base_in  = CMP_W'(last_ff);
                              burst_in = BURST_FULL;
                           end else begin
                              handover_in = 1'b1;
                           end
                        end
                        default: begin
                           done_in = '0;
                        end
                     endcase
                  end
                  CMD_ERROR: begin
                     mode_in = MODE_OFF;
                     on_in   = 1'b0;
                  end
                  default: begin
                     dropped_in = 1'b0;
                  end
               endcase
            end
         end
         BK_DECODE: begin
            handover_in = 1'b0;
            rd_in       = (rd_ff == PTR_LAST) ? '0 : rd_ff + 1'b1;
            cnt_in      = cnt_ff - 1'b1;
            if (head_swap) begin
               period_in = head_ff.period;
               base_in   = CMP_W'(last_ff);
               burst_in  = BURST_FULL;
            end else if (head_skip) begin
               mode_in = MODE_OFF;
               on_in   = 1'b0;
            end else begin
               on_in     = 1'b1;
               period_in = head_ff.period;
               base_in   = timer_ff;
               if (head_ff.req_mode == REQ_VELOCITY) begin
                  mode_in  = MODE_VELOCITY;
                  steps_in = '0;
                  burst_in = BURST_FULL;
               end else begin
                  mode_in  = MODE_POSITION;
                  steps_in = head_ff.steps;
                  burst_in = burst_cap(head_ff.steps);
               end
            end
         end
         BK_REDUCE: begin
            if (red_status.done) begin
               prev_in  = red_result[LANE_BASE];
               phase_in = 1'b0;
               pcnt_in  = '0;
            end
         end
         BK_BURST: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               word_valid_in = 1'b1;
               cmp_in        = CMP_W'(word);
               last_item_in  = word_last;
               mode_out_in   = mode_ff;
               on_out_in     = on_ff;
               done_out_in   = DONE_W'(done_ff);
               drop_out_in   = dropped_ff;
               prev_in       = word;
               phase_in      = !phase_ff;
               if (phase_ff) begin
                  pcnt_in = pcnt_ff + 1'b1;
               end
               if (word_last) begin
                  last_in = word;
               end
            end
         end
         BK_STATUS: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               word_valid_in = 1'b0;
               cmp_in        = '0;
               last_item_in  = 1'b1;
               mode_out_in   = mode_ff;
               on_out_in     = on_ff;
               done_out_in   = DONE_W'(done_ff);
               drop_out_in   = dropped_ff;
            end
         end
         default: begin
            handover_in = handover_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rd_ff        <= '0;
         wr_ff        <= '0;
         cnt_ff       <= '0;
         mode_ff      <= MODE_OFF;
         on_ff        <= 1'b0;
         period_ff    <= '0;
         steps_ff     <= '0;
         burst_ff     <= '0;
         last_ff      <= '0;
         handover_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_ff        <= rd_in;
         wr_ff        <= wr_in;
         cnt_ff       <= cnt_in;
         mode_ff      <= mode_in;
         on_ff        <= on_in;
         period_ff    <= period_in;
         steps_ff     <= steps_in;
         burst_ff     <= burst_in;
         last_ff      <= last_in;
         handover_ff  <= handover_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      timer_ff      <= timer_in;
      base_ff       <= base_in;
      done_ff       <= done_in;
      dropped_ff    <= dropped_in;
      prev_ff       <= prev_in;
      phase_ff      <= phase_in;
      pcnt_ff       <= pcnt_in;
      word_valid_ff <= word_valid_in;
      cmp_ff        <= cmp_in;
      last_item_ff  <= last_item_in;
      mode_out_ff   <= mode_out_in;
      on_out_ff     <= on_out_in;
      done_out_ff   <= done_out_in;
      drop_out_ff   <= drop_out_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_ff] <= mem_wdata;
      end
      head_ff <= mem[rd_ff];
   end

endmodule

`default_nettype wire

// ----- design/sps_checker.sv -----
// ----------------------------------------------------------------------------
// Stepper pulse scheduler port checker
// Watches the response channel of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire logic                          word_valid,
   input  wire logic                          last,
   input  wire logic [sps_pkg::MODE_W-1:0]    mode_now,
   input  wire logic                          output_enabled,
   input  wire logic [sps_pkg::DONE_W-1:0]    pulses_done,
   input  wire logic                          request_dropped
);
   import sps_pkg::*;

   hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(word_valid) && $stable(last))
      else $error("stalled response item changed");

   status_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !word_valid |-> last)
      else $error("status item not marked last");

   enable_tracks_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> output_enabled == (mode_now != MODE_OFF))
      else $error("output enable disagrees with mode");

   drop_is_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && request_dropped |-> !word_valid && pulses_done == '0)
      else $error("dropped request produced words or pulse count");

endmodule

bind stepper_pulse_scheduler_unit sps_checker u_sps_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .word_valid      (rsp_ch.word_valid),
   .last            (rsp_ch.last),
   .mode_now        (rsp_ch.mode_now),
   .output_enabled  (rsp_ch.output_enabled),
   .pulses_done     (rsp_ch.pulses_done),
   .request_dropped (rsp_ch.request_dropped)
);

`default_nettype wire

// ----- tb/sps_result_monitor.sv -----
// ----------------------------------------------------------------------------
// Stepper pulse scheduler result monitor
// Watches the request, response and pulse width channels, keeps its own copy
// of the move queue and motor state, works out the compare words and status
// of every request transfer and checks each response transfer against them.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_result_monitor #(
   parameter int BURST_PULSES = sps_pkg::BURST_PULSES_DEF,
   parameter int QUEUE_DEPTH  = sps_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   sps_req_if        req_ch,
   sps_rsp_if        rsp_ch,
   sps_csr_if        csr_ch,
   output int        mismatches,
   output int        results_owed,
   output int        results_seen
);
   import sps_pkg::*;

   typedef struct packed {
      logic                word_valid;
      logic [CMP_W-1:0]    compare_value;
      logic                last;
      mode_type            mode_now;
      logic                output_enabled;
      logic [DONE_W-1:0]   pulses_done;
      logic                request_dropped;
   } sched_item_type;

   sched_item_type      expected_q[$];
   logic [CMP_W-1:0]    burst_words[$];

   move_type            move_fifo[QUEUE_DEPTH];
   int                  rd_ptr;
   int                  wr_ptr;
   int                  move_count;
   mode_type            cur_mode;
   logic [PERIOD_W-1:0] cur_period;
   logic [STEPS_W-1:0]  steps_to_go;
   int                  burst_len;
   logic [CMP_W-1:0]    prev_word;
   logic                output_live;
   logic [PW_W-1:0]     width_reg;
   int                  fail_total;
   int                  seen_total;

   function automatic move_type take_move();
      move_type m;
      m = move_fifo[rd_ptr];
      rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH;
      move_count--;
      return m;
   endfunction

   function automatic void emit_burst(logic [CMP_W-1:0] from);
      logic [CMP_W-1:0] w;
      burst_len = BURST_PULSES;
      if (cur_mode == MODE_POSITION && steps_to_go < BURST_PULSES) begin
         burst_len = int'(steps_to_go);
      end
      w = from;
      for (int i = 0; i < burst_len; i++) begin
         w = w + cur_period;
         burst_words.push_back(w);
         w = w + width_reg;
         burst_words.push_back(w);
      end
      if (burst_len > 0) begin
         prev_word = w;
      end
   endfunction

   function automatic void stop_motor();
      cur_mode = MODE_OFF;
      output_live = 1'b0;
   endfunction

   function automatic void try_start(logic [TIMER_W-1:0] timer);
      move_type m;
      while (cur_mode == MODE_OFF && move_count > 0) begin
         m = take_move();
         if (m.req_mode == REQ_POSITION && m.steps == '0) begin
            continue;
         end
         cur_mode    = (m.req_mode == REQ_VELOCITY) ? MODE_VELOCITY : MODE_POSITION;
         cur_period  = m.period;
         steps_to_go = (m.req_mode == REQ_VELOCITY) ? '0 : m.steps;
         output_live = 1'b1;
         emit_burst(timer);
      end
   endfunction

   function automatic void predict_event(cmd_type cmd, logic rmode, logic [PERIOD_W-1:0] period,
                                         logic [STEPS_W-1:0] steps, logic [TIMER_W-1:0] timer);
      logic           dropped;
      logic [DONE_W-1:0] done;
      logic           status_only;
      move_type       m;
      sched_item_type item;
      dropped = 1'b0;
      done    = '0;
      burst_words.delete();
      case (cmd)
         CMD_ENQUEUE: begin
            if (move_count >= QUEUE_DEPTH) begin
               dropped = 1'b1;
            end else begin
               move_fifo[wr_ptr] = '{req_mode: rmode, period: period, steps: steps};
               wr_ptr = (wr_ptr + 1) % QUEUE_DEPTH;
               move_count++;
            end
         end
         CMD_START: try_start(timer);
         CMD_DONE: begin
            if (cur_mode == MODE_POSITION) begin
               done = DONE_W'(burst_len);
               steps_to_go = (steps_to_go >= burst_len) ? steps_to_go - STEPS_W'(burst_len) : '0;
               if (steps_to_go != '0) begin
                  emit_burst(prev_word);
               end else begin
                  stop_motor();
                  try_start(timer);
               end
            end else if (cur_mode == MODE_VELOCITY) begin
               done = DONE_W'(burst_len);
               if (move_count == 0) begin
                  emit_burst(prev_word);
               end else if (move_fifo[rd_ptr].req_mode == REQ_VELOCITY) begin
                  m = take_move();
                  cur_period = m.period;
                  emit_burst(prev_word);
               end else begin
                  stop_motor();
                  try_start(timer);
               end
            end
         end
         default: stop_motor();
      endcase
      status_only = (burst_words.size() == 0);
      if (status_only) begin
         burst_words.push_back('0);
      end
      foreach (burst_words[i]) begin
         item.word_valid      = !status_only;
         item.compare_value   = burst_words[i];
         item.last            = (i == burst_words.size() - 1);
         item.mode_now        = cur_mode;
         item.output_enabled  = output_live;
         item.pulses_done     = done;
         item.request_dropped = dropped;
         expected_q.push_back(item);
      end
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_total++;
      end
   endfunction

   always @(posedge clock) begin
      sched_item_type want;
      if (reset) begin
         expected_q.delete();
         foreach (move_fifo[i]) move_fifo[i] = '0;
         rd_ptr      = 0;
         wr_ptr      = 0;
         move_count  = 0;
         cur_mode    = MODE_OFF;
         cur_period  = '0;
         steps_to_go = '0;
         burst_len   = 0;
         prev_word   = '0;
         output_live = 1'b0;
         width_reg   = PULSE_WIDTH_RST;
         fail_total  = 0;
         seen_total  = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen_total++;
            if (expected_q.size() == 0) begin
               $error("result transfer with no expectation: compare_value %0d",
                      rsp_ch.compare_value);
               fail_total++;
            end else begin
               want = expected_q.pop_front();
               check_field("word_valid", want.word_valid, rsp_ch.word_valid);
               check_field("compare_value", want.compare_value, rsp_ch.compare_value);
               check_field("last", want.last, rsp_ch.last);
               check_field("mode_now", want.mode_now, rsp_ch.mode_now);
               check_field("output_enabled", want.output_enabled, rsp_ch.output_enabled);
               check_field("pulses_done", want.pulses_done, rsp_ch.pulses_done);
               check_field("request_dropped", want.request_dropped, rsp_ch.request_dropped);
            end
         end
         if (csr_ch.valid && csr_ch.ready) begin
            width_reg = csr_ch.pulse_width;
         end
         if (req_ch.valid && req_ch.ready) begin
            predict_event(cmd_type'(req_ch.command), req_ch.req_mode, req_ch.req_period,
                          req_ch.req_steps, req_ch.timer_count);
         end
      end
      mismatches   <= fail_total;
      results_owed <= expected_q.size();
      results_seen <= seen_total;
   end

endmodule

`default_nettype wire

// ----- tb/stepper_pulse_scheduler_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Stepper pulse scheduler testbench
// Directed events for idle, start, zero-step, wrap, velocity swap, hand-over,
// error and full-queue cases, then random move sequences over several pulse
// widths with random stalls on both channels; a result monitor checks words.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_pulse_scheduler_unit_tb;
   import sps_pkg::*;

   localparam int RUN_LIMIT    = 400000;
   localparam int PHASE_EVENTS = 72;

   logic clock = 1'b0;
   logic reset;
   logic calm;
   int   cycles;
   int   events_sent;
   int   width_writes;
   int   mismatches;
   int   results_owed;
   int   results_seen;

   sps_req_if req_ch ();
   sps_rsp_if rsp_ch ();
   sps_csr_if csr_ch ();

   stepper_pulse_scheduler_unit dut (
      .clock,
      .reset,
      .req_ch,
      .rsp_ch,
      .csr_ch
   );

   sps_result_monitor monitor (
      .clock,
      .reset,
      .req_ch,
      .rsp_ch,
      .csr_ch,
      .mismatches,
      .results_owed,
      .results_seen
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= calm || ($urandom_range(99) >= 7);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == RUN_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_event(cmd_type cmd, logic rmode, logic [PERIOD_W-1:0] period,
                             logic [STEPS_W-1:0] steps, logic [TIMER_W-1:0] timer);
      while (!calm && $urandom_range(99) < 7) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.command     <= cmd;
      req_ch.req_mode    <= rmode;
      req_ch.req_period  <= period;
      req_ch.req_steps   <= steps;
      req_ch.timer_count <= timer;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      events_sent++;
   endtask

   task automatic send_command(cmd_type cmd);
      send_event(cmd, 1'($urandom), 16'($urandom), 24'($urandom), 16'($urandom));
   endtask

   task automatic enqueue_random();
      logic [PERIOD_W-1:0] period;
      logic [STEPS_W-1:0]  steps;
      int                  pick;
      pick = $urandom_range(9);
      period = (pick == 0) ? '0 : (pick == 1) ? '1 : 16'($urandom);
      if ($urandom_range(9) < 3) begin
         send_event(CMD_ENQUEUE, REQ_VELOCITY, period, 24'($urandom), 16'($urandom));
      end else begin
         pick = $urandom_range(19);
         if (pick < 2) begin
            steps = '0;
         end else if (pick == 2) begin
            steps = 24'($urandom);
         end else begin
            steps = 24'($urandom_range(1, 40));
         end
         send_event(CMD_ENQUEUE, REQ_POSITION, period, steps, 16'($urandom));
      end
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
   endtask

   task automatic write_width(logic [PW_W-1:0] width);
      csr_ch.valid       <= 1'b1;
      csr_ch.pulse_width <= width;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      width_writes++;
   endtask

   task automatic run_moves(int budget);
      int start_count;
      start_count = events_sent;
      while (events_sent - start_count < budget) begin
         if ($urandom_range(9) == 0) begin
            send_command(cmd_type'(CMD_W'($urandom_range(3))));
         end else begin
            repeat ($urandom_range(1, 3)) enqueue_random();
            send_command(CMD_START);
            repeat ($urandom_range(1, 6)) send_command(CMD_DONE);
            if ($urandom_range(6) == 0) begin
               send_command(CMD_ERROR);
            end
         end
      end
   endtask

   initial begin
      events_sent         = 0;
      width_writes        = 0;
      calm               <= 1'b0;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.command     <= CMD_ENQUEUE;
      req_ch.req_mode    <= REQ_POSITION;
      req_ch.req_period  <= '0;
      req_ch.req_steps   <= '0;
      req_ch.timer_count <= '0;
      csr_ch.valid       <= 1'b0;
      csr_ch.pulse_width <= PULSE_WIDTH_RST;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_command(CMD_DONE);
      send_command(CMD_START);
      send_event(CMD_ENQUEUE, REQ_POSITION, 16'd0, 24'd0, 16'd0);
      send_event(CMD_ENQUEUE, REQ_POSITION, 16'd100, 24'd3, 16'd0);
      send_event(CMD_START, REQ_POSITION, 16'd0, 24'd0, 16'hFFFF);
      send_event(CMD_DONE, REQ_POSITION, 16'd0, 24'd0, 16'd7);
      send_event(CMD_ENQUEUE, REQ_VELOCITY, 16'hFFFF, 24'hFFFFFF, 16'hFFFF);
      send_event(CMD_ENQUEUE, REQ_VELOCITY, 16'd1, 24'd5, 16'd0);
      send_event(CMD_ENQUEUE, REQ_POSITION, 16'd500, 24'd20, 16'd0);
      send_event(CMD_START, REQ_POSITION, 16'd0, 24'd0, 16'h8000);
      send_event(CMD_DONE, REQ_POSITION, 16'd0, 24'd0, 16'd0);
      send_event(CMD_DONE, REQ_POSITION, 16'd0, 24'd0, 16'h1234);
      send_event(CMD_DONE, REQ_POSITION, 16'd0, 24'd0, 16'd0);
      send_event(CMD_DONE, REQ_POSITION, 16'd0, 24'd0, 16'd0);
      send_event(CMD_ENQUEUE, REQ_VELOCITY, 16'd3000, 24'd0, 16'd0);
      send_command(CMD_START);
      send_command(CMD_ERROR);
      send_command(CMD_ERROR);
      repeat (QUEUE_DEPTH_DEF + 1) enqueue_random();
      drain();

      write_width(16'd1);
      run_moves(PHASE_EVENTS);
      drain();
      write_width(16'hFFFF);
      calm <= 1'b1;
      run_moves(PHASE_EVENTS);
      drain();
      calm <= 1'b0;
      write_width(16'($urandom_range(2, 65534)));
      run_moves(PHASE_EVENTS);
      drain();
      write_width(16'($urandom_range(1, 65535)));
      run_moves(PHASE_EVENTS);
      drain();
      repeat (64) @(posedge clock);

      $display("Covered %0d events and %0d result items over %0d pulse width settings,",
               events_sent, results_seen, width_writes + 1);
      $display("including queue overflow, zero-step moves, velocity swaps and errors.");
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
